/* src/gsfd_pkg.sv */
// Shared types, constants and the CRC-8 helper for the gas sensor frame decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package gsfd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [3:0]  FRAME_LAST  = 4'd8;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] RH_SCALE    = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam int unsigned FIFO_DEPTH  = 2;

  localparam logic [1:0] STATUS_OK = 2'd0;

  // Position inside a word: two data bytes, then the check byte.
  typedef enum logic [1:0] {
    SLOT_HIGH  = 2'd0,
    SLOT_LOW   = 2'd1,
    SLOT_CHECK = 2'd2
  } slot_e;

  // One finished frame as handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] gas_word;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
  } frame_rec_t;

  // Result item as it leaves the block.
  typedef struct packed {
    logic [13:0]        rh_x100;
    logic signed [14:0] temp_cdeg;
    logic [15:0]        co2_ppm;
    logic [1:0]         status;
  } result_t;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/gsfd_front.sv */
// Front part: accepts response bytes, tracks the frame position, runs the CRC
// and assembles the three words. Depends on gsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsfd_front
  import gsfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_start_i,
  output logic            in_ready_o,
  output logic            push_o,
  output frame_rec_t      push_rec_o,
  input  wire logic       full_i
);

  logic [3:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] gas_q, gas_d, temp_q, temp_d, hum_q, hum_d;
  logic [1:0]  fail_q, fail_d, fail_cur;
  logic [1:0]  word_idx;
  slot_e       slot;
  logic        take;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    pos = (in_start_i || pos_q > FRAME_LAST) ? 4'd0 : pos_q;
  end

  // Position to word and slot.
  always_comb begin
    unique case (pos)
      4'd0:    begin word_idx = 2'd0; slot = SLOT_HIGH;  end
      4'd1:    begin word_idx = 2'd0; slot = SLOT_LOW;   end
      4'd2:    begin word_idx = 2'd0; slot = SLOT_CHECK; end
      4'd3:    begin word_idx = 2'd1; slot = SLOT_HIGH;  end
      4'd4:    begin word_idx = 2'd1; slot = SLOT_LOW;   end
      4'd5:    begin word_idx = 2'd1; slot = SLOT_CHECK; end
      4'd6:    begin word_idx = 2'd2; slot = SLOT_HIGH;  end
      4'd7:    begin word_idx = 2'd2; slot = SLOT_LOW;   end
      default: begin word_idx = 2'd2; slot = SLOT_CHECK; end
    endcase
  end

  always_comb begin
    pos_d    = pos_q;
    crc_d    = crc_q;
    gas_d    = gas_q;
    temp_d   = temp_q;
    hum_d    = hum_q;
    fail_d   = fail_q;
    fail_cur = (pos == 4'd0) ? STATUS_OK : fail_q;
    if (take) begin
      fail_d = fail_cur;
      case (slot)
        SLOT_HIGH: begin
          crc_d = crc8_fold(CRC_INIT, in_byte_i);
          case (word_idx)
            2'd0:    gas_d[15:8]  = in_byte_i;
            2'd1:    temp_d[15:8] = in_byte_i;
            default: hum_d[15:8]  = in_byte_i;
          endcase
        end
        SLOT_LOW: begin
          crc_d = crc8_fold(crc_q, in_byte_i);
          case (word_idx)
            2'd0:    gas_d[7:0]  = in_byte_i;
            2'd1:    temp_d[7:0] = in_byte_i;
            default: hum_d[7:0]  = in_byte_i;
          endcase
        end
        default: begin
          if (crc_q != in_byte_i && fail_cur == STATUS_OK) begin
            fail_d = word_idx + 2'd1;
          end
        end
      endcase
      pos_d = (pos == FRAME_LAST) ? 4'd0 : pos + 4'd1;
    end
  end

  // The ninth byte is a check byte, so the words are already complete here.
  assign push_o               = take && (pos == FRAME_LAST);
  assign push_rec_o.status    = fail_d;
  assign push_rec_o.gas_word  = gas_q;
  assign push_rec_o.temp_word = temp_q;
  assign push_rec_o.hum_word  = hum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 4'd0;
      crc_q  <= CRC_INIT;
      gas_q  <= 16'd0;
      temp_q <= 16'd0;
      hum_q  <= 16'd0;
      fail_q <= STATUS_OK;
    end else begin
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      gas_q  <= gas_d;
      temp_q <= temp_d;
      hum_q  <= hum_d;
      fail_q <= fail_d;
    end
  end

endmodule

`default_nettype wire

/* src/gsfd_fifo.sv */
// Short queue of finished frame records between the front and back parts.
// Depends on gsfd_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none

module gsfd_fifo
  import gsfd_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire frame_rec_t  push_rec_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output frame_rec_t       pop_rec_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  frame_rec_t       mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_rec_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/gsfd_back.sv */
// Back part: scales temperature and humidity and drives the result register.
// Two stages: constant multiply, then divide by 65535 and offset. Depends on gsfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gsfd_back
  import gsfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire frame_rec_t rec_i,
  output logic            pop_o,
  output logic            out_valid_o,
  output result_t         out_res_o,
  input  wire logic       out_ready_i
);

  logic        s1_v_q, out_v_q;
  logic [1:0]  s1_status_q;
  logic [15:0] s1_gas_q;
  logic [30:0] s1_tprod_q;
  logic [29:0] s1_rprod_q;
  logic        out_adv, s1_adv;
  logic [31:0] t_sum;
  logic [30:0] r_sum;
  logic [14:0] t_quo;
  logic [13:0] r_quo;
  result_t     res_d, res_q;

  assign out_adv = !out_v_q || out_ready_i;
  assign s1_adv  = !s1_v_q || out_adv;
  assign pop_o   = s1_adv && !empty_i;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_status_q <= rec_i.status;
      s1_gas_q    <= rec_i.gas_word;
      s1_tprod_q  <= 31'(TEMP_SCALE) * 31'(rec_i.temp_word);
      s1_rprod_q  <= 30'(RH_SCALE) * 30'(rec_i.hum_word);
    end
  end

  // x / 65535 == (x + (x >> 16) + 1) >> 16 for the product ranges seen here.
  always_comb begin
    t_sum = {1'b0, s1_tprod_q} + 32'(s1_tprod_q[30:16]) + 32'd1;
    r_sum = {1'b0, s1_rprod_q} + 31'(s1_rprod_q[29:16]) + 31'd1;
    t_quo = t_sum[30:16];
    r_quo = r_sum[29:16];
    res_d.status = s1_status_q;
    if (s1_status_q == STATUS_OK) begin
      res_d.co2_ppm   = s1_gas_q;
      res_d.temp_cdeg = signed'(t_quo - TEMP_OFFSET);
      res_d.rh_x100   = r_quo;
    end else begin
      res_d.co2_ppm   = 16'd0;
      res_d.temp_cdeg = 15'sd0;
      res_d.rh_x100   = 14'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= !empty_i;
      end
      if (out_adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

/* src/gas_sensor_frame_decoder_unit.sv */
// Gas sensor frame decoder: one response byte per item, one result per nine bytes.
// Throughput: one byte per cycle; the front accepts a byte whenever the frame queue has room.
// Path of a frame: its queue entry is written when the ninth byte is accepted, then the
// multiply stage and the divide-and-offset stage each register it in turn, unless m_axis_tready holds the output.
// Reset (asynchronous, active low) empties the queue and pipeline and restarts at byte 0.
`timescale 1ns / 1ps
`default_nettype none

module gas_sensor_frame_decoder_unit
  import gsfd_pkg::*;
#(
  parameter int unsigned QueueDepth = FIFO_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // [1:0] status, [17:2] co2_ppm,
                                           // [32:18] temp_cdeg, [46:33] rh_x100, [47] zero
);

  logic       push, full, pop, empty;
  frame_rec_t push_rec, pop_rec;
  result_t    res;

  gsfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_start_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .push_rec_o (push_rec),
    .full_i     (full)
  );

  gsfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_rec_o  (pop_rec)
  );

  gsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule

`default_nettype wire
